// ===== design/mtc_pkg.sv =====
`timescale 1ns / 1ps

package mtc_pkg;

   // code table size and the longest token that can still match
   localparam int CodeCount   = 36;
   localparam int MaxSymbols  = 5;
   localparam int QueueDepth  = 2;

   // ascii codes used on both sides
   localparam logic [7:0] SpaceChar   = 8'h20;
   localparam logic [7:0] SlashChar   = 8'h2F;
   localparam logic [7:0] DotChar     = 8'h2E;
   localparam logic [7:0] DashChar    = 8'h2D;
   localparam logic [7:0] NewlineChar = 8'h0A;

   // separator that goes in front of an encoded letter
   typedef enum logic [1:0] {
      PRE_NONE  = 2'd0,
      PRE_SPACE = 2'd1,
      PRE_GAP   = 2'd3
   } pre_type;

   // one unit of work handed from the front to the back
   typedef struct packed {
      pre_type     pre;
      logic [2:0]  sym_len;
      logic [4:0]  sym_pat;
      logic        has_char;
      logic [7:0]  char_val;
      logic        has_nl;
   } job_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] idx;
   } index_type;

   typedef struct packed {
      logic [2:0] len;
      logic [4:0] pat;
   } code_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] ch;
   } char_hit_type;

   // letter (either case) or digit to code table index
   function automatic index_type char_index(input logic [7:0] c);
      index_type  r;
      logic [7:0] d;
      r = '0;
      d = '0;
      if (c inside {[8'h61:8'h7A]}) begin
         d = c - 8'h61;
         r.hit = 1'b1;
         r.idx = d[5:0];
      end else if (c inside {[8'h41:8'h5A]}) begin
         d = c - 8'h41;
         r.hit = 1'b1;
         r.idx = d[5:0];
      end else if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30 + 8'd26;
         r.hit = 1'b1;
         r.idx = d[5:0];
      end
      return r;
   endfunction

   // dot-dash code per index, bit i of pat set when symbol i is a dash
   function automatic code_type code_entry(input logic [5:0] idx);
      code_type r;
      case (idx)
         6'd0:    r = '{3'd2, 5'b00010};
         6'd1:    r = '{3'd4, 5'b00001};
         6'd2:    r = '{3'd4, 5'b00101};
         6'd3:    r = '{3'd3, 5'b00001};
         6'd4:    r = '{3'd1, 5'b00000};
         6'd5:    r = '{3'd4, 5'b00100};
         6'd6:    r = '{3'd3, 5'b00011};
         6'd7:    r = '{3'd4, 5'b00000};
         6'd8:    r = '{3'd2, 5'b00000};
         6'd9:    r = '{3'd4, 5'b01110};
         6'd10:   r = '{3'd3, 5'b00101};
         6'd11:   r = '{3'd4, 5'b00010};
         6'd12:   r = '{3'd2, 5'b00011};
         6'd13:   r = '{3'd2, 5'b00001};
         6'd14:   r = '{3'd3, 5'b00111};
         6'd15:   r = '{3'd4, 5'b00110};
         6'd16:   r = '{3'd4, 5'b01011};
         6'd17:   r = '{3'd3, 5'b00010};
         6'd18:   r = '{3'd3, 5'b00000};
         6'd19:   r = '{3'd1, 5'b00001};
         6'd20:   r = '{3'd3, 5'b00100};
         6'd21:   r = '{3'd4, 5'b01000};
         6'd22:   r = '{3'd3, 5'b00110};
         6'd23:   r = '{3'd4, 5'b01001};
         6'd24:   r = '{3'd4, 5'b01101};
         6'd25:   r = '{3'd4, 5'b00011};
         6'd26:   r = '{3'd5, 5'b11111};
         6'd27:   r = '{3'd5, 5'b11110};
         6'd28:   r = '{3'd5, 5'b11100};
         6'd29:   r = '{3'd5, 5'b11000};
         6'd30:   r = '{3'd5, 5'b10000};
         6'd31:   r = '{3'd5, 5'b00000};
         6'd32:   r = '{3'd5, 5'b00001};
         6'd33:   r = '{3'd5, 5'b00011};
         6'd34:   r = '{3'd5, 5'b00111};
         6'd35:   r = '{3'd5, 5'b01111};
         default: r = '0;
      endcase
      return r;
   endfunction

   // table index to upper-case letter or digit
   function automatic logic [7:0] index_char(input logic [5:0] idx);
      logic [7:0] r;
      if (idx < 6'd26) begin
         r = 8'h41 + {2'b00, idx};
      end else begin
         r = 8'h30 + {2'b00, idx} - 8'd26;
      end
      return r;
   endfunction

   // token to character, compared against every table entry in parallel
   function automatic char_hit_type code_lookup(input logic [2:0] len, input logic [4:0] pat);
      char_hit_type r;
      code_type     e;
      r = '0;
      e = '0;
      for (int i = 0; i < CodeCount; i++) begin
         e = code_entry(6'(i));
         if (!r.hit && e.len == len && e.pat == pat && len != 3'd0) begin
            r.hit = 1'b1;
            r.ch  = index_char(6'(i));
         end
      end
      return r;
   endfunction

   // number of separator bytes
   function automatic logic [1:0] pre_count(input pre_type p);
      logic [1:0] r;
      case (p)
         PRE_NONE:  r = 2'd0;
         PRE_SPACE: r = 2'd1;
         PRE_GAP:   r = 2'd3;
         default:   r = 2'd0;
      endcase
      return r;
   endfunction

   // number of bytes a job emits
   function automatic logic [3:0] job_total(input job_type j);
      return {2'b00, pre_count(j.pre)} + {1'b0, j.sym_len}
             + {3'b000, j.has_char} + {3'b000, j.has_nl};
   endfunction

endpackage

// ===== design/mtc_front.sv =====
`timescale 1ns / 1ps

module mtc_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_char_in,
   input  logic            req_end_of_message,
   input  logic            q_full,
   output logic            q_push,
   output mtc_pkg::job_type q_job
);

   logic       mode_ff, mode_in;
   logic       started_ff, started_in;
   logic       word_break_ff, word_break_in;
   logic [2:0] tok_len_ff, tok_len_in;
   logic [4:0] tok_pat_ff, tok_pat_in;
   logic       tok_slash_ff, tok_slash_in;
   logic       tok_bad_ff, tok_bad_in;

   logic                  accept;
   mtc_pkg::index_type    enc_idx;
   mtc_pkg::code_type     enc_code;
   mtc_pkg::char_hit_type dec_hit;
   mtc_pkg::char_hit_type flush_hit;
   logic                  bad_tmp;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // table lookups for both directions
   always_comb begin
      enc_idx  = mtc_pkg::char_index(req_char_in);
      enc_code = mtc_pkg::code_entry(enc_idx.idx);
      dec_hit  = mtc_pkg::code_lookup(tok_len_ff, tok_pat_ff);
      flush_hit = '0;
      if (tok_slash_ff) begin
         flush_hit.hit = 1'b1;
         flush_hit.ch  = mtc_pkg::SpaceChar;
      end else if (!tok_bad_ff) begin
         flush_hit = dec_hit;
      end
   end

   // classify the request, build the job and the next state
   always_comb begin
      mode_in       = csr_wr_en ? csr_wr_data : mode_ff;
      started_in    = started_ff;
      word_break_in = word_break_ff;
      tok_len_in    = tok_len_ff;
      tok_pat_in    = tok_pat_ff;
      tok_slash_in  = tok_slash_ff;
      tok_bad_in    = tok_bad_ff;
      q_push        = 1'b0;
      q_job         = '0;
      bad_tmp       = tok_bad_ff;
      if (accept) begin
         if (req_end_of_message) begin
            // flush in decode mode, newline always, then clear
            q_push         = 1'b1;
            q_job.has_nl   = 1'b1;
            q_job.has_char = mode_ff && flush_hit.hit;
            q_job.char_val = flush_hit.ch;
            started_in     = 1'b0;
            word_break_in  = 1'b0;
            tok_len_in     = '0;
            tok_pat_in     = '0;
            tok_slash_in   = 1'b0;
            tok_bad_in     = 1'b0;
         end else if (!mode_ff) begin
            // encode
            if (req_char_in == mtc_pkg::SpaceChar) begin
               if (started_ff) begin
                  word_break_in = 1'b1;
               end
            end else if (enc_idx.hit) begin
               q_push        = 1'b1;
               q_job.sym_len = enc_code.len;
               q_job.sym_pat = enc_code.pat;
               if (started_ff) begin
                  q_job.pre = word_break_ff ? mtc_pkg::PRE_GAP : mtc_pkg::PRE_SPACE;
               end else begin
                  q_job.pre = mtc_pkg::PRE_NONE;
               end
               started_in    = 1'b1;
               word_break_in = 1'b0;
            end
         end else begin
            // decode
            if (req_char_in == mtc_pkg::SpaceChar) begin
               q_push         = flush_hit.hit;
               q_job.has_char = flush_hit.hit;
               q_job.char_val = flush_hit.ch;
               tok_len_in     = '0;
               tok_pat_in     = '0;
               tok_slash_in   = 1'b0;
               tok_bad_in     = 1'b0;
            end else if (tok_len_ff == 3'd0 && !tok_bad_ff && !tok_slash_ff
                         && req_char_in == mtc_pkg::SlashChar) begin
               tok_slash_in = 1'b1;
            end else begin
               if (tok_slash_ff) begin
                  tok_slash_in = 1'b0;
                  bad_tmp      = 1'b1;
               end
               if (!bad_tmp && (req_char_in inside {mtc_pkg::DotChar, mtc_pkg::DashChar})
                   && tok_len_ff < 3'(mtc_pkg::MaxSymbols)) begin
                  if (req_char_in == mtc_pkg::DashChar) begin
                     tok_pat_in = tok_pat_ff | (5'b00001 << tok_len_ff);
                  end
                  tok_len_in = tok_len_ff + 3'd1;
                  tok_bad_in = bad_tmp;
               end else begin
                  tok_bad_in = 1'b1;
               end
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         started_ff    <= 1'b0;
         word_break_ff <= 1'b0;
         tok_len_ff    <= '0;
         tok_pat_ff    <= '0;
         tok_slash_ff  <= 1'b0;
         tok_bad_ff    <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         started_ff    <= started_in;
         word_break_ff <= word_break_in;
         tok_len_ff    <= tok_len_in;
         tok_pat_ff    <= tok_pat_in;
         tok_slash_ff  <= tok_slash_in;
         tok_bad_ff    <= tok_bad_in;
      end
   end

endmodule

// ===== design/mtc_queue.sv =====
`timescale 1ns / 1ps

module mtc_queue #(
   parameter int Depth = mtc_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mtc_pkg::job_type push_data,
   input  logic             pop,
   output mtc_pkg::job_type pop_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   mtc_pkg::job_type slot_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == CntW'(Depth);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/mtc_back.sv =====
`timescale 1ns / 1ps

module mtc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  mtc_pkg::job_type q_job,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last_of_run
);

   mtc_pkg::job_type job_ff, job_in;
   logic             job_valid_ff, job_valid_in;
   logic [2:0]       pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   logic       out_free;
   logic       emit;
   logic       last;
   logic [3:0] total;
   logic [3:0] pos_ext;
   logic [3:0] pre_n;
   logic [3:0] sym_off;
   logic [3:0] tail_off;
   logic [4:0] pat_shift;
   logic [7:0] cur_char;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = job_valid_ff && out_free;
   assign total    = mtc_pkg::job_total(job_ff);
   assign pos_ext  = {1'b0, pos_ff};
   assign last     = (pos_ext + 4'd1) == total;
   assign q_pop    = q_not_empty && (!job_valid_ff || (emit && last));

   // byte at the current position: separator, symbols, character, newline
   always_comb begin
      pre_n     = {2'b00, mtc_pkg::pre_count(job_ff.pre)};
      sym_off   = pos_ext - pre_n;
      tail_off  = sym_off - {1'b0, job_ff.sym_len};
      pat_shift = job_ff.sym_pat >> sym_off[2:0];
      if (pos_ext < pre_n) begin
         cur_char = (pos_ext == 4'd1) ? mtc_pkg::SlashChar : mtc_pkg::SpaceChar;
      end else if (sym_off < {1'b0, job_ff.sym_len}) begin
         cur_char = pat_shift[0] ? mtc_pkg::DashChar : mtc_pkg::DotChar;
      end else if (job_ff.has_char && tail_off == 4'd0) begin
         cur_char = job_ff.char_val;
      end else begin
         cur_char = mtc_pkg::NewlineChar;
      end
   end

   // sequencing of the current job and the output register
   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = cur_char;
         rsp_last_in  = last;
         if (last) begin
            job_valid_in = 1'b0;
            pos_in       = '0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (q_pop) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
         pos_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== design/morse_text_codec_top.sv =====
`timescale 1ns / 1ps

// Morse text codec: text to dot-dash code, or dot-dash tokens back to text.
// Request channel (req_valid/req_ready): one ASCII byte in req_char_in, or an
// end-of-message marker in req_end_of_message that flushes and ends with a newline.
// Response channel (rsp_valid/rsp_ready): one ASCII byte per response, with
// rsp_last_of_run set on the final byte a request produces (up to eight).
// A request that produces nothing (a skipped byte, a space) sends no response.
// csr_wr_en/csr_wr_data write decode_mode (0 encode, 1 decode); write it only
// while the codec is idle. The mode write keeps the message state.
// A request's job is registered in the queue slot, then the job register, and its
// first byte in the output register. One response byte per cycle while the
// receiver is ready; a request produces 1 to 8 bytes (2 to 8 for an encoded
// letter after the first), and the single-byte output register sets that pace.
// Requests that give nothing are taken one per cycle while the queue has room.
// A small job queue sits between the classifier and the byte sequencer, so
// requests keep being taken while the receiver stalls, until the queue fills.
// Reset clears the mode to encode and all message state; no clearing pass.

module morse_text_codec_top #(
   parameter int QueueDepth = mtc_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_not_empty;
   mtc_pkg::job_type q_in_job;
   mtc_pkg::job_type q_out_job;

   // classifier and message state
   mtc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_in        (req_char_in),
      .req_end_of_message (req_end_of_message),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_job              (q_in_job)
   );

   // job queue
   mtc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_job),
      .pop       (q_pop),
      .pop_data  (q_out_job),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // byte sequencer
   mtc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_job           (q_out_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // queue never written while full
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("job queue overflow");

   // queue never read while empty
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_not_empty)
      else $error("job queue underflow");

   // an end marker always yields a job
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_message) |-> q_push)
      else $error("end marker produced no job");

   // every queued job emits at least one and at most eight bytes
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (mtc_pkg::job_total(q_in_job) != 4'd0
                  && mtc_pkg::job_total(q_in_job) <= 4'd8))
      else $error("job with bad byte count");

endmodule

// ===== bench/morse_check.sv =====
`timescale 1ns / 1ps

module morse_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_message,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_char,
   input  logic       rsp_last_of_run,
   output int         fail_count,
   output int         bytes_waiting,
   output int         bytes_checked
);

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_byte_type;

   // predicted output bytes, oldest first
   out_byte_type expected_bytes [$];
   logic [7:0]   step_chars [$];
   int           errors  = 0;
   int           checked = 0;

   // codec state as the block should hold it
   logic       decoding;
   logic       started;
   logic       word_break;
   logic [2:0] tok_len;
   logic [4:0] tok_pat;
   logic       tok_slash;
   logic       tok_bad;

   // dot-dash text per table entry, letters first, then digits
   function automatic string morse_string(input int idx);
      string s;
      case (idx)
         0: s = ".-";     1: s = "-...";   2: s = "-.-.";   3: s = "-..";
         4: s = ".";      5: s = "..-.";   6: s = "--.";    7: s = "....";
         8: s = "..";     9: s = ".---";   10: s = "-.-";   11: s = ".-..";
         12: s = "--";    13: s = "-.";    14: s = "---";   15: s = ".--.";
         16: s = "--.-";  17: s = ".-.";   18: s = "...";   19: s = "-";
         20: s = "..-";   21: s = "...-";  22: s = ".--";   23: s = "-..-";
         24: s = "-.--";  25: s = "--..";
         26: s = "-----"; 27: s = ".----"; 28: s = "..---"; 29: s = "...--";
         30: s = "....-"; 31: s = "....."; 32: s = "-...."; 33: s = "--...";
         34: s = "---.."; 35: s = "----.";
         default: s = "";
      endcase
      return s;
   endfunction

   // letter of either case or digit to table entry, -1 otherwise
   function automatic int letter_index(input logic [7:0] c);
      if (c >= "a" && c <= "z") return int'(c - "a");
      if (c >= "A" && c <= "Z") return int'(c - "A");
      if (c >= "0" && c <= "9") return 26 + int'(c - "0");
      return -1;
   endfunction

   // character for a gathered token, zero when nothing matches
   function automatic logic [7:0] token_char(input logic [2:0] len, input logic [4:0] pat);
      string      s;
      logic [4:0] p;
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < mtc_pkg::CodeCount; i++) begin
         s = morse_string(i);
         p = '0;
         for (int k = 0; k < s.len(); k++) begin
            if (s[k] == mtc_pkg::DashChar) p[k] = 1'b1;
         end
         if (r == 8'h00 && s.len() == int'(len) && p == pat) begin
            r = (i < 26) ? "A" + 8'(i) : "0" + 8'(i - 26);
         end
      end
      return r;
   endfunction

   function void clear_message();
      started    = 1'b0;
      word_break = 1'b0;
      tok_len    = '0;
      tok_pat    = '0;
      tok_slash  = 1'b0;
      tok_bad    = 1'b0;
   endfunction

   // end of a decode token: slash gives a space, a known code its character
   function void flush_token();
      logic [7:0] c;
      if (tok_slash) begin
         step_chars.push_back(mtc_pkg::SpaceChar);
      end else if (!tok_bad && tok_len != 3'd0) begin
         c = token_char(tok_len, tok_pat);
         if (c != 8'h00) step_chars.push_back(c);
      end
      tok_len   = '0;
      tok_pat   = '0;
      tok_slash = 1'b0;
      tok_bad   = 1'b0;
   endfunction

   // bytes one accepted request should produce
   function void predict_codec_bytes(input logic [7:0] c, input logic eom);
      string        s;
      int           ix;
      out_byte_type b;
      step_chars.delete();
      if (eom) begin
         if (decoding) flush_token();
         step_chars.push_back(mtc_pkg::NewlineChar);
         clear_message();
      end else if (!decoding) begin
         if (c == mtc_pkg::SpaceChar) begin
            if (started) word_break = 1'b1;
         end else begin
            ix = letter_index(c);
            if (ix >= 0) begin
               if (started) begin
                  if (word_break) begin
                     step_chars.push_back(mtc_pkg::SpaceChar);
                     step_chars.push_back(mtc_pkg::SlashChar);
                  end
                  step_chars.push_back(mtc_pkg::SpaceChar);
               end
               s = morse_string(ix);
               for (int k = 0; k < s.len(); k++) step_chars.push_back(s[k]);
               started    = 1'b1;
               word_break = 1'b0;
            end
         end
      end else begin
         if (c == mtc_pkg::SpaceChar) begin
            flush_token();
         end else if (tok_len == 3'd0 && !tok_bad && !tok_slash
                      && c == mtc_pkg::SlashChar) begin
            tok_slash = 1'b1;
         end else begin
            // slash followed by anything spoils the token
            if (tok_slash) begin
               tok_slash = 1'b0;
               tok_bad   = 1'b1;
            end
            if (!tok_bad && (c == mtc_pkg::DotChar || c == mtc_pkg::DashChar)
                && tok_len < mtc_pkg::MaxSymbols) begin
               if (c == mtc_pkg::DashChar) tok_pat[tok_len] = 1'b1;
               tok_len = tok_len + 3'd1;
            end else begin
               tok_bad = 1'b1;
            end
         end
      end
      foreach (step_chars[k]) begin
         b.ch   = step_chars[k];
         b.last = (k == step_chars.size() - 1);
         expected_bytes.push_back(b);
      end
   endfunction

   // responses are checked before this edge's request is predicted
   always @(posedge clock) begin
      out_byte_type want;
      if (reset) begin
         decoding = 1'b0;
         clear_message();
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_bytes.size() == 0) begin
               errors++;
               $error("unexpected response: out_char %h last_of_run %b",
                      rsp_out_char, rsp_last_of_run);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_char !== want.ch) begin
                  errors++;
                  $error("out_char expected %h actual %h", want.ch, rsp_out_char);
               end
               if (rsp_last_of_run !== want.last) begin
                  errors++;
                  $error("last_of_run expected %b actual %b", want.last, rsp_last_of_run);
               end
            end
         end
         if (csr_wr_en) decoding = csr_wr_data;
         if (req_valid && req_ready) predict_codec_bytes(req_char_in, req_end_of_message);
      end
      fail_count    <= errors;
      bytes_waiting <= expected_bytes.size();
      bytes_checked <= checked;
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int CycleLimit   = 2000000;
   localparam int ItemTarget   = 400;
   localparam int PhaseCount   = 8;
   localparam int SettleCycles = 12;
   localparam int HoldCycles   = 200;

   logic       clock;
   logic       reset              = 1'b1;
   logic       csr_wr_en          = 1'b0;
   logic       csr_wr_data        = 1'b0;
   logic       req_valid          = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in        = 8'h00;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready          = 1'b1;
   logic [7:0] rsp_out_char;
   logic       rsp_last_of_run;

   int fail_count;
   int bytes_waiting;
   int bytes_checked;
   int requests_sent = 0;
   int cycle_count   = 0;
   bit idle_gaps     = 1'b1;
   bit hold_rsp      = 1'b0;

   morse_text_codec_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_in        (req_char_in),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   morse_check codec_check (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_in        (req_char_in),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_of_run    (rsp_last_of_run),
      .fail_count         (fail_count),
      .bytes_waiting      (bytes_waiting),
      .bytes_checked      (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL morse_text_codec_top");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // receiver: random stalls, plus one long hold on request
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_rsp  <= 1'b0;
            rsp_ready <= 1'b1;
         end else if (idle_gaps && $urandom_range(0, 3) == 0) begin
            stall = pick_gap() + 1;
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one request and hold it until taken
   task automatic send_req(input logic [7:0] c, input logic eom);
      int gap;
      req_valid          <= 1'b1;
      req_char_in        <= c;
      req_end_of_message <= eom;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      gap = idle_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_req(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // stop offering and let every predicted byte drain
   task automatic wait_idle();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_waiting != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // text for encoding: letters and digits, spaces, end markers, odd bytes
   task automatic random_text_item();
      int         roll;
      logic [7:0] c;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         c = ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
      end else if (roll < 65) begin
         c = "0" + 8'($urandom_range(0, 9));
      end else if (roll < 83) begin
         c = mtc_pkg::SpaceChar;
      end else if (roll < 90) begin
         send_end();
         return;
      end else begin
         c = 8'($urandom_range(0, 255));
      end
      send_req(c, 1'b0);
   endtask

   // one decode token and its separator, mostly well formed
   task automatic random_token();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         repeat ($urandom_range(1, 5))
            send_req($urandom_range(0, 1) ? mtc_pkg::DashChar : mtc_pkg::DotChar, 1'b0);
      end else if (roll < 75) begin
         send_req(mtc_pkg::SlashChar, 1'b0);
      end else if (roll < 82) begin
         // too many symbols
         repeat ($urandom_range(6, 8))
            send_req($urandom_range(0, 1) ? mtc_pkg::DashChar : mtc_pkg::DotChar, 1'b0);
      end else if (roll < 90) begin
         // slash not alone, or a stray byte inside the token
         send_req($urandom_range(0, 1) ? mtc_pkg::SlashChar : mtc_pkg::DotChar, 1'b0);
         send_req(8'($urandom_range(0, 255)), 1'b0);
         send_req(mtc_pkg::DashChar, 1'b0);
      end
      if ($urandom_range(0, 99) < 10) send_end();
      else send_req(mtc_pkg::SpaceChar, 1'b0);
   endtask

   // stimulus
   initial begin
      int base;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // encoding: leading space, both cases, word gap, digits, skipped bytes
      write_mode(1'b0);
      send_text(" Az  09");
      send_req(8'h00, 1'b0);
      send_req(8'hFF, 1'b0);
      send_req(mtc_pkg::DotChar, 1'b0);
      send_end();
      send_end();

      // decoding: lone slash, longest code, empty token, slash then a symbol
      write_mode(1'b1);
      send_text("/ -----  /.");
      send_end();

      // random phases, alternating mode; the message is left open at each switch
      for (int phase = 0; phase < PhaseCount; phase++) begin
         write_mode(phase[0]);
         idle_gaps <= (phase != 2 && phase != 5);
         if (phase == 2) hold_rsp <= 1'b1;
         base = requests_sent;
         while (requests_sent - base < ItemTarget / PhaseCount) begin
            if (phase[0]) random_token();
            else random_text_item();
            if (phase == 4 && requests_sent - base == 25) wait_idle();
         end
      end

      wait_idle();
      $display("covered %0d requests in encode and decode, %0d response bytes checked",
               requests_sent, bytes_checked);
      $display("including a long receiver hold and a full drain mid-message");
      if (fail_count == 0) begin
         $display("PASS morse_text_codec_top");
      end else begin
         $display("FAIL morse_text_codec_top");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/mtc_pkg.sv
design/mtc_front.sv
design/mtc_queue.sv
design/mtc_back.sv
design/morse_text_codec_top.sv
bench/morse_check.sv
bench/tb.sv
